FILE: sv/online_lp_dual_price_allocator_defines.svh
// Assertion macros for the allocator; clk and rst are taken from the using module.
`ifndef ONLINE_LP_DUAL_PRICE_ALLOCATOR_DEFINES_SVH
`define ONLINE_LP_DUAL_PRICE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define OLPDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define OLPDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/olpda_pkg.sv
// ----------------------------------------------------------------------------
// olpda_pkg
// Shared types, widths and constants of the dual price allocator.
// ----------------------------------------------------------------------------
package olpda_pkg;

  localparam int ROW_W   = 10;
  localparam int COEF_W  = 18;
  localparam int VAL_W   = 32;
  localparam int ID_W    = 20;
  localparam int UNITS_W = 16;
  localparam int STEP_W  = 24;
  localparam int PASS_W  = 8;
  localparam int PRICE_W = 32;
  localparam int STAMP_W = 32;
  localparam int SHARE_W = 32;
  localparam int INV_W   = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEASIBLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

  localparam logic [STEP_W-1:0]  STEP_RESET = 24'd16384;
  localparam logic [PASS_W-1:0]  PASS_RESET = 8'd1;
  localparam logic [UNITS_W-1:0] MAX_RESET  = 16'd1;
  localparam logic [UNITS_W-1:0] BINARY_CAP = 16'd1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_E1, S_E2, S_E3, S_E4, S_E5, S_DECIDE, S_DIV, S_END,
    S_SEL, S_APPLY, S_W_RD, S_W_BUF, S_W_MEM, S_W_WR, S_EMIT
  } state_t;

  typedef enum logic [1:0] {PASS_PRICE, PASS_CHECK, PASS_CHARGE} pass_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [INV_W-1:0] sat48(input logic signed [INV_W:0] v);
    logic signed [INV_W-1:0] r;
    if (v[INV_W] != v[INV_W-1]) begin
      r = v[INV_W] ? {1'b1, {(INV_W-1){1'b0}}} : {1'b0, {(INV_W-1){1'b1}}};
    end else begin
      r = v[INV_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/olpda_item_if.sv
// ----------------------------------------------------------------------------
// olpda_item_if
// Input item channel: row loads and column nonzero entries.
// ----------------------------------------------------------------------------
interface olpda_item_if import olpda_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [ROW_W-1:0]         row_index;
  logic signed [COEF_W-1:0] coef;
  logic [SHARE_W-1:0]       row_rhs;
  logic [SHARE_W-1:0]       row_share;
  logic signed [VAL_W-1:0]  col_value;
  logic [ID_W-1:0]          col_id;
  logic                     last_entry;
  logic                     empty_column;

  modport source (output valid, opcode, row_index, coef, row_rhs, row_share, col_value,
                  col_id, last_entry, empty_column, input ready);
  modport sink (input valid, opcode, row_index, coef, row_rhs, row_share, col_value,
                col_id, last_entry, empty_column, output ready);
endinterface

FILE: sv/olpda_result_if.sv
// ----------------------------------------------------------------------------
// olpda_result_if
// Result channel: one decision per column.
// ----------------------------------------------------------------------------
interface olpda_result_if import olpda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    col_id_out;
  logic [UNITS_W-1:0] units;
  logic               applied;

  modport source (output valid, col_id_out, units, applied, input ready);
  modport sink (input valid, col_id_out, units, applied, output ready);
endinterface

FILE: sv/olpda_cfg_if.sv
// ----------------------------------------------------------------------------
// olpda_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface olpda_cfg_if import olpda_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/olpda_ram.sv
// ----------------------------------------------------------------------------
// olpda_ram
// Simple dual-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module olpda_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: sv/olpda_div.sv
// ----------------------------------------------------------------------------
// olpda_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module olpda_div import olpda_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] qs;
  logic [CNT_W-1:0]     cnt;
  logic                 running;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;

  assign trial = {rem, qs[DIV_NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        qs      <= req.num;
        den     <= req.den;
      end else if (running) begin
        if (trial >= {1'b0, den}) begin
          rem <= DIV_DEN_W'(trial - {1'b0, den});
          qs  <= {qs[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_DEN_W-1:0];
          qs  <= {qs[DIV_NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = qs;
endmodule

FILE: sv/online_lp_dual_price_allocator.sv
// ----------------------------------------------------------------------------
// online_lp_dual_price_allocator
// Online LP allocator with lazily decayed per-row dual prices.
// ----------------------------------------------------------------------------
// After reset the block sweeps the price memory over all ROWS rows and accepts no
// item meanwhile (configuration writes are taken). A column entry goes through
// read, decay multiply, decay apply and write back, coefficient multiply and
// accumulate, all through the price memory. A column end is decided directly in
// binary mode or by the bit-serial divider in integer mode when a division is
// needed; the column is closed, the price update walks the buffered entries when
// units are granted, the next walk is picked, a feasibility check (if enabled,
// with a final apply step) walks the entry buffer, and so does the inventory
// charge unless the check fails; the result is emitted once the previous result
// beat has been taken.
// ----------------------------------------------------------------------------
`include "online_lp_dual_price_allocator_defines.svh"

module online_lp_dual_price_allocator import olpda_pkg::*; #(
  parameter int ROWS    = 1024,
  parameter int MAX_NNZ = 64
) (
  input  logic           clk,
  input  logic           rst,
  olpda_item_if.sink     item,
  olpda_cfg_if.sink      cfg,
  olpda_result_if.source result
);
  localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EB  = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int CW  = $clog2(MAX_NNZ + 1);
  localparam int EW  = RAW + COEF_W;
  localparam int PW  = PRICE_W + STAMP_W;
  localparam int SW  = SHARE_W + INV_W;
  localparam logic [16:0]   ROW_LIMIT = 17'(ROWS);
  localparam logic [RAW-1:0] ROW_LAST = RAW'(ROWS - 1);
  localparam logic [CW-1:0]  CNT_FULL = CW'(MAX_NNZ);

  state_t state, state_next;
  pass_t  pass;

  logic [STEP_W-1:0]  step_size;
  logic [PASS_W-1:0]  pass_count;
  logic               check_feasible;
  logic [UNITS_W-1:0] max_units;

  logic [RAW-1:0]            clr_cnt;
  logic [STAMP_W-1:0]        update_count;
  logic [CW-1:0]             entry_count;
  logic signed [INV_W-1:0]   dot_acc;
  logic signed [COEF_W-1:0]  e_coef;
  logic signed [VAL_W-1:0]   e_value;
  logic [ID_W-1:0]           e_id;
  logic                      e_last;
  logic [RAW-1:0]            e_row;
  logic [PRICE_W-1:0]        ep_price;
  logic [STAMP_W-1:0]        ep_stamp;
  logic [55:0]               per;
  logic [63:0]               m_hi;
  logic [55:0]               m_lo;
  logic signed [50:0]        ep_prod;
  logic [UNITS_W-1:0]        units_r;
  logic                      applied_r;
  logic                      fail;
  logic [CW-1:0]             k;
  logic [RAW-1:0]            w_row;
  logic signed [COEF_W-1:0]  w_coef;
  logic [PRICE_W-1:0]        w_price;
  logic [SHARE_W-1:0]        w_share;
  logic signed [INV_W-1:0]   w_inv;
  logic signed [58:0]        w_prod;
  logic                      out_valid;
  logic [ID_W-1:0]           out_id;
  logic [UNITS_W-1:0]        out_units;
  logic                      out_applied;

  logic           pm_we, pm_re, sm_we, sm_re, eb_we, eb_re;
  logic [RAW-1:0] pm_waddr, pm_raddr, sm_waddr, sm_raddr;
  logic [PW-1:0]  pm_wdata, pm_rdata;
  logic [SW-1:0]  sm_wdata, sm_rdata;
  logic [EB-1:0]  eb_waddr, eb_raddr;
  logic [EW-1:0]  eb_wdata, eb_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                   item_acc, cfg_acc, row_ok, emit_ok, walk_last;
  logic [RAW-1:0]         row_addr;
  logic [RAW-1:0]         eb_row;
  logic signed [INV_W-1:0] val_ext;
  logic                   binary, dot_zero, dot_neg, val_neg, val_pos, need_div;
  logic [UNITS_W-1:0]     direct_units;
  logic [31:0]            elapsed;
  logic [64:0]            dec;
  logic [PRICE_W-1:0]     decayed;
  logic signed [48:0]     dsum;
  logic signed [33:0]     pdiff;
  logic signed [36:0]     np_sum;
  logic [PRICE_W-1:0]     np;
  logic signed [INV_W:0]  inv_diff;
  logic [CW-1:0]          k_inc;

  olpda_ram #(.WIDTH(PW), .DEPTH(ROWS)) u_price_mem (
    .clk, .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .re(pm_re), .raddr(pm_raddr), .rdata(pm_rdata)
  );

  olpda_ram #(.WIDTH(SW), .DEPTH(ROWS)) u_stock_mem (
    .clk, .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .re(sm_re), .raddr(sm_raddr), .rdata(sm_rdata)
  );

  olpda_ram #(.WIDTH(EW), .DEPTH(MAX_NNZ)) u_entry_buf (
    .clk, .we(eb_we), .waddr(eb_waddr), .wdata(eb_wdata),
    .re(eb_re), .raddr(eb_raddr), .rdata(eb_rdata)
  );

  olpda_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign item_acc   = item.valid && item.ready;
  assign cfg_acc    = cfg.valid && cfg.ready;
  assign row_ok     = {7'b0, item.row_index} < ROW_LIMIT;
  assign row_addr   = RAW'(item.row_index);
  assign eb_row     = eb_rdata[EW-1:COEF_W];
  assign emit_ok    = !out_valid || result.ready;
  assign k_inc      = k + 1'b1;
  assign walk_last  = (k_inc == entry_count);

  assign result.valid      = out_valid;
  assign result.col_id_out = out_id;
  assign result.units      = out_units;
  assign result.applied    = out_applied;

  // decision
  assign val_ext  = INV_W'(e_value);
  assign binary   = (max_units == BINARY_CAP);
  assign dot_zero = (dot_acc == '0);
  assign dot_neg  = dot_acc[INV_W-1];
  assign val_neg  = e_value[VAL_W-1];
  assign val_pos  = !val_neg && (e_value != '0);
  assign need_div = !binary && !dot_zero && !(!dot_neg && val_neg) && !(dot_neg && val_pos);
  assign direct_units = binary ? UNITS_W'(val_ext >= dot_acc) :
                        (dot_zero && val_pos) ? max_units : '0;
  assign div_req.start = (state == S_DECIDE) && need_div;
  assign div_req.num   = val_neg ? DIV_NUM_W'(-e_value) : DIV_NUM_W'(e_value);
  assign div_req.den   = dot_neg ? DIV_DEN_W'(-dot_acc) : DIV_DEN_W'(dot_acc);

  // arithmetic
  assign elapsed  = update_count - ep_stamp;
  assign dec      = {1'b0, m_hi} + 65'(m_lo[55:24]);
  assign decayed  = (dec >= 65'(ep_price)) ? '0 : (ep_price - dec[31:0]);
  assign dsum     = {dot_acc[INV_W-1], dot_acc} + 49'(ep_prod >>> 16);
  assign pdiff    = 34'(w_coef) - $signed({2'b0, sm_rdata[SW-1:INV_W]});
  assign np_sum   = $signed({5'b0, w_price}) + 37'(w_prod >>> 24);
  assign np       = np_sum[36] ? '0 :
                    (np_sum > 37'sh0FFFFFFFF) ? {PRICE_W{1'b1}} : np_sum[31:0];
  assign inv_diff = {w_inv[INV_W-1], w_inv} - 49'(w_coef);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == ROW_LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (item_acc && item.opcode == OP_ENTRY) begin
          if (item.empty_column) begin
            state_next = S_DECIDE;
          end else if (row_ok) begin
            state_next = S_E1;
          end else if (item.last_entry) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_E1: state_next = S_E2;
      S_E2: state_next = S_E3;
      S_E3: state_next = S_E4;
      S_E4: state_next = S_E5;
      S_E5: state_next = e_last ? S_DECIDE : S_IDLE;
      S_DECIDE: state_next = need_div ? S_DIV : S_END;
      S_DIV: if (div_rsp.done) state_next = S_END;
      S_END: state_next = (units_r != '0 && entry_count != '0) ? S_W_RD : S_SEL;
      S_SEL: begin
        if (entry_count == '0) begin
          state_next = S_EMIT;
        end else if (check_feasible && units_r != '0) begin
          state_next = S_W_RD;
        end else if (!check_feasible) begin
          state_next = S_W_RD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_APPLY: state_next = fail ? S_EMIT : S_W_RD;
      S_W_RD:  state_next = S_W_BUF;
      S_W_BUF: state_next = S_W_MEM;
      S_W_MEM: state_next = S_W_WR;
      S_W_WR: begin
        if (!walk_last) begin
          state_next = S_W_RD;
        end else begin
          case (pass)
            PASS_PRICE: state_next = S_SEL;
            PASS_CHECK: state_next = S_APPLY;
            default:    state_next = S_EMIT;
          endcase
        end
      end
      S_EMIT: if (emit_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pm_we = 1'b0; pm_waddr = e_row; pm_wdata = {decayed, update_count};
    pm_re = 1'b0; pm_raddr = row_addr;
    sm_we = 1'b0; sm_waddr = row_addr;
    sm_wdata = {item.row_share, INV_W'(item.row_rhs * pass_count)};
    sm_re = 1'b0; sm_raddr = row_addr;
    eb_we = 1'b0; eb_waddr = entry_count[EB-1:0]; eb_wdata = {e_row, e_coef};
    eb_re = 1'b0; eb_raddr = k[EB-1:0];
    case (state)
      S_CLEAR: begin
        pm_we = 1'b1; pm_waddr = clr_cnt; pm_wdata = '0;
      end
      S_IDLE: begin
        if (item_acc && row_ok) begin
          if (item.opcode == OP_LOAD) begin
            sm_we = 1'b1;
          end else if (!item.empty_column) begin
            pm_re = 1'b1; sm_re = 1'b1;
          end
        end
      end
      S_E3: pm_we = 1'b1;
      S_E5: eb_we = (entry_count < CNT_FULL);
      S_W_RD: eb_re = 1'b1;
      S_W_BUF: begin
        pm_re = 1'b1; pm_raddr = eb_row;
        sm_re = 1'b1; sm_raddr = eb_row;
      end
      S_W_WR: begin
        if (pass == PASS_PRICE) begin
          pm_we = 1'b1; pm_waddr = w_row; pm_wdata = {np, update_count};
        end else if (pass == PASS_CHARGE) begin
          sm_we = 1'b1; sm_waddr = w_row; sm_wdata = {w_share, sat48(inv_diff)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      pass           <= PASS_PRICE;
      clr_cnt        <= '0;
      update_count   <= '0;
      entry_count    <= '0;
      dot_acc        <= '0;
      out_valid      <= 1'b0;
      step_size      <= STEP_RESET;
      pass_count     <= PASS_RESET;
      check_feasible <= 1'b0;
      max_units      <= MAX_RESET;
      fail           <= 1'b0;
      k              <= '0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        case (cfg.index)
          CFG_STEP:     step_size      <= cfg.data;
          CFG_PASS:     pass_count     <= cfg.data[PASS_W-1:0];
          CFG_FEASIBLE: check_feasible <= cfg.data[0];
          CFG_MAX:      max_units      <= cfg.data[UNITS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && result.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        S_IDLE: begin
          if (item_acc) begin
            e_coef  <= item.coef;
            e_value <= item.col_value;
            e_id    <= item.col_id;
            e_last  <= item.last_entry;
            e_row   <= row_addr;
          end
        end
        S_E1: begin
          ep_price <= pm_rdata[PW-1:STAMP_W];
          ep_stamp <= pm_rdata[STAMP_W-1:0];
          per      <= step_size * sm_rdata[SW-1:INV_W];
        end
        S_E2: begin
          m_hi <= per[55:24] * elapsed;
          m_lo <= per[23:0] * elapsed;
        end
        S_E3: ep_price <= decayed;
        S_E4: ep_prod <= e_coef * $signed({1'b0, ep_price});
        S_E5: begin
          dot_acc <= sat48(dsum);
          if (entry_count < CNT_FULL) begin
            entry_count <= entry_count + 1'b1;
          end
        end
        S_DECIDE: units_r <= direct_units;
        S_DIV: begin
          if (div_rsp.done) begin
            units_r <= (div_rsp.quo > DIV_NUM_W'(max_units)) ? max_units
                                                             : div_rsp.quo[UNITS_W-1:0];
          end
        end
        S_END: begin
          update_count <= update_count + 1'b1;
          k    <= '0;
          pass <= PASS_PRICE;
          fail <= 1'b0;
        end
        S_SEL: begin
          k <= '0;
          if (check_feasible && units_r != '0 && entry_count != '0) begin
            pass <= PASS_CHECK;
          end else begin
            pass      <= PASS_CHARGE;
            applied_r <= !check_feasible || (units_r != '0);
          end
        end
        S_APPLY: begin
          k         <= '0;
          pass      <= PASS_CHARGE;
          applied_r <= !fail;
        end
        S_W_BUF: begin
          w_row  <= eb_row;
          w_coef <= eb_rdata[COEF_W-1:0];
        end
        S_W_MEM: begin
          w_price <= pm_rdata[PW-1:STAMP_W];
          w_share <= sm_rdata[SW-1:INV_W];
          w_inv   <= sm_rdata[INV_W-1:0];
        end
        S_W_WR: begin
          k <= k_inc;
          if (pass == PASS_CHECK && inv_diff[INV_W]) begin
            fail <= 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid   <= 1'b1;
            out_id      <= e_id;
            out_units   <= units_r;
            out_applied <= applied_r;
            entry_count <= '0;
            dot_acc     <= '0;
          end
        end
        default: ;
      endcase
      if (state == S_W_MEM) begin
        w_prod <= $signed({1'b0, step_size}) * pdiff;
      end
    end
  end

  `OLPDA_ASSERT_NOW(a_cnt_bound, 1'b1, entry_count <= CNT_FULL, "entry count overflow")
  `OLPDA_ASSERT_NEXT(a_emit_clears, state == S_EMIT && emit_ok, entry_count == '0 && dot_acc == '0 && result.valid, "column end left state behind")
  `OLPDA_ASSERT_NEXT(a_div_wait, div_req.start, state == S_DIV && !div_rsp.done, "divider start without wait")
endmodule
